// ===== rtl/core/isim_pkg.sv =====
// ----------------------------------------------------------------------------
// isim_pkg
// Shared types and codes for the interval set insert and merge block: the
// item structs, the status codes and the controller to datapath links.
// ----------------------------------------------------------------------------
package isim_pkg;

    localparam int unsigned VAL_W   = 32;
    localparam int unsigned ENTRY_W = 5;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef struct packed {
        logic [VAL_W-1:0] range_first;
        logic [VAL_W-1:0] range_last;
        logic             dry_run;
    } t_in_item;

    typedef struct packed {
        logic               changed;
        t_status            status;
        logic [ENTRY_W-1:0] entry_count;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic scan;
        logic mv_init;
        logic move;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic mv_done;
    } t_sts;

endpackage

// ===== rtl/core/isim_dp.sv =====
// ----------------------------------------------------------------------------
// isim_dp
// Datapath: range tables in memory, scan counters that locate the merge
// window, the move engine that compacts or opens the table, and the result.
// ----------------------------------------------------------------------------
module isim_dp #(
    parameter int unsigned MAX_RANGES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  isim_pkg::t_cmd       i_cmd,
    input  isim_pkg::t_in_item   i_item,
    output isim_pkg::t_sts       o_sts,
    output isim_pkg::t_out_item  o_res
);

    localparam int unsigned CW = $clog2(MAX_RANGES + 1);
    localparam int unsigned IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int unsigned VW = isim_pkg::VAL_W;

    logic [VW-1:0] r_start_mem [MAX_RANGES];
    logic [VW-1:0] r_end_mem   [MAX_RANGES];

    logic [VW-1:0] r_lo, r_hi;
    logic          r_dry;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ptr, r_first, r_stop;
    logic          r_rvld, r_fnd;
    logic [VW-1:0] r_sf, r_ef, r_el;
    logic [VW-1:0] r_rd_s, r_rd_e;
    logic [CW-1:0] r_src, r_dst, r_mvcnt;
    logic          r_down, r_mvld;
    logic [IW-1:0] r_wdst;
    isim_pkg::t_out_item r_res;

    logic          rd_scan, rd_move, rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [VW-1:0] wr_s, wr_e;
    logic [VW:0]   e_p1, hi_p1;
    logic [CW-1:0] merged, n_new;
    logic          bad, covered, full, changed, wr_need;
    logic [VW-1:0] nlo, nhi;
    isim_pkg::t_status status;

    assign rd_scan = i_cmd.scan && (r_ptr != r_count);
    assign rd_move = i_cmd.move && (r_mvcnt != '0);
    assign rd_en   = rd_scan || rd_move;
    assign rd_addr = rd_scan ? r_ptr[IW-1:0] : r_src[IW-1:0];

    assign e_p1  = {1'b0, r_rd_e} + {{VW{1'b0}}, 1'b1};
    assign hi_p1 = {1'b0, r_hi} + {{VW{1'b0}}, 1'b1};

    assign bad     = r_lo > r_hi;
    assign merged  = r_stop - r_first;
    assign covered = (merged == CW'(1)) && (r_sf <= r_lo) && (r_ef >= r_hi);
    assign full    = (merged == '0) && (r_count >= CW'(MAX_RANGES));
    assign changed = !bad && !full && !covered;
    assign wr_need = changed && !r_dry;
    assign nlo     = ((merged != '0) && (r_sf < r_lo)) ? r_sf : r_lo;
    assign nhi     = ((merged != '0) && (r_el > r_hi)) ? r_el : r_hi;
    assign n_new   = (merged == '0) ? r_count + CW'(1) : r_count - merged + CW'(1);

    always_comb begin
        priority if (bad) begin
            status = isim_pkg::ST_BAD;
        end else if (full) begin
            status = isim_pkg::ST_FULL;
        end else begin
            status = isim_pkg::ST_OK;
        end
    end

    assign wr_en   = r_mvld || (i_cmd.finish && wr_need);
    assign wr_addr = r_mvld ? r_wdst : r_first[IW-1:0];
    assign wr_s    = r_mvld ? r_rd_s : nlo;
    assign wr_e    = r_mvld ? r_rd_e : nhi;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_s <= r_start_mem[rd_addr];
            r_rd_e <= r_end_mem[rd_addr];
        end
        if (wr_en) begin
            r_start_mem[wr_addr] <= wr_s;
            r_end_mem[wr_addr]   <= wr_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rvld  <= 1'b0;
            r_mvld  <= 1'b0;
            r_mvcnt <= '0;
        end else begin
            r_rvld <= rd_scan;
            r_mvld <= rd_move;
            r_wdst <= r_dst[IW-1:0];

            if (i_cmd.start) begin
                r_lo    <= i_item.range_first;
                r_hi    <= i_item.range_last;
                r_dry   <= i_item.dry_run;
                r_ptr   <= '0;
                r_first <= '0;
                r_stop  <= '0;
                r_fnd   <= 1'b0;
                r_rvld  <= 1'b0;
            end else begin
                if (rd_scan) begin
                    r_ptr <= r_ptr + CW'(1);
                end
                if (r_rvld) begin
                    if (e_p1 < {1'b0, r_lo}) begin
                        r_first <= r_first + CW'(1);
                    end else if (!r_fnd) begin
                        r_fnd <= 1'b1;
                        r_sf  <= r_rd_s;
                        r_ef  <= r_rd_e;
                    end
                    if ({1'b0, r_rd_s} <= hi_p1) begin
                        r_stop <= r_stop + CW'(1);
                        r_el   <= r_rd_e;
                    end
                end
            end

            if (i_cmd.mv_init) begin
                r_down <= (merged == '0);
                if (!wr_need) begin
                    r_mvcnt <= '0;
                end else if (merged == '0) begin
                    r_mvcnt <= r_count - r_first;
                    r_src   <= r_count - CW'(1);
                    r_dst   <= r_count;
                end else begin
                    r_mvcnt <= r_count - r_stop;
                    r_src   <= r_stop;
                    r_dst   <= r_first + CW'(1);
                end
            end else if (rd_move) begin
                r_mvcnt <= r_mvcnt - CW'(1);
                if (r_down) begin
                    r_src <= r_src - CW'(1);
                    r_dst <= r_dst - CW'(1);
                end else begin
                    r_src <= r_src + CW'(1);
                    r_dst <= r_dst + CW'(1);
                end
            end

            if (i_cmd.finish) begin
                r_res.changed     <= changed;
                r_res.status      <= status;
                if (wr_need) begin
                    r_count           <= n_new;
                    r_res.entry_count <= isim_pkg::ENTRY_W'(n_new);
                end else begin
                    r_res.entry_count <= isim_pkg::ENTRY_W'(r_count);
                end
            end
        end
    end

    assign o_sts.scan_done = (r_ptr == r_count) && !r_rvld;
    assign o_sts.mv_done   = (r_mvcnt == '0) && !r_mvld;
    assign o_res           = r_res;

endmodule

// ===== rtl/core/isim_ctrl.sv =====
// ----------------------------------------------------------------------------
// isim_ctrl
// Controller: sequences accept, table scan, move setup, table rewrite and
// result hand-off, and owns the handshake of both channels.
// ----------------------------------------------------------------------------
module isim_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  isim_pkg::t_sts i_sts,
    output isim_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PLAN,
        S_MOVE,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_ovld;
    logic   can_fin;

    assign can_fin = !r_ovld || i_out_ready;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: o_cmd.start   = i_in_valid;
            S_SCAN: o_cmd.scan    = 1'b1;
            S_PLAN: o_cmd.mv_init = 1'b1;
            S_MOVE: o_cmd.move    = 1'b1;
            S_FIN:  o_cmd.finish  = can_fin;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            if (o_cmd.finish) begin
                r_ovld <= 1'b1;
            end else if (r_ovld && i_out_ready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (i_sts.scan_done) r_state <= S_PLAN;
                end
                S_PLAN: r_state <= S_MOVE;
                S_MOVE: begin
                    if (i_sts.mv_done) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (can_fin) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;

endmodule

// ===== rtl/core/interval_set_insert_merge.sv =====
// ----------------------------------------------------------------------------
// interval_set_insert_merge
// Sorted table of disjoint, non-touching inclusive ranges with merge on insert.
// ----------------------------------------------------------------------------
// Each item offers one range; it is fused with every stored range that
// overlaps or touches it and the table is rewritten in order (only reported
// on in dry run, or for a bad range, a full table or a covered range). One
// result item follows each input item. The tables sit in a memory with one
// read and one write port. A new item is taken while the previous result
// still waits at the output.
// ----------------------------------------------------------------------------
module interval_set_insert_merge #(
    parameter int unsigned MAX_RANGES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  isim_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output isim_pkg::t_out_item o_out_item
);

    isim_pkg::t_cmd cmd;
    isim_pkg::t_sts sts;

    isim_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    isim_dp #(
        .MAX_RANGES (MAX_RANGES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_in_item),
        .o_sts   (sts),
        .o_res   (o_out_item)
    );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for interval_set_insert_merge.
// ----------------------------------------------------------------------------
// Each range item sent to the block is run through a local copy of the sorted
// range table. That copy predicts the changed flag, the status and the entry
// count of the result. Results are matched in order against the predictions.
// Directed items first cover the ends of the value space, bad ranges, dry
// runs and a full table. Random epochs then fill one region of the value
// space at a time with ranges that touch, bridge and cover the stored ones.
// Each epoch ends by folding its region into a block that grows from the
// bottom or from the top, which keeps the table from saturating. Both sides
// stall at random, except in the randomly chosen quiet epochs.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned MAX_RANGES  = 16;
    localparam int unsigned REGION_W    = 26;
    localparam int unsigned EPOCHS      = 24;
    localparam int unsigned EPOCH_ITEMS = 59;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned TAIL_CYCLES = 2 * MAX_RANGES + 16;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    isim_pkg::t_in_item  in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    isim_pkg::t_out_item out_item;

    logic [31:0] span_lo [MAX_RANGES];
    logic [31:0] span_hi [MAX_RANGES];
    int          span_n = 0;

    isim_pkg::t_out_item expected_q[$];
    int          n_sent    = 0;
    int          n_checked = 0;
    int          n_err     = 0;
    int          n_full    = 0;
    int          n_cycles  = 0;
    int          ready_hold = 0;
    bit          quiet     = 1'b0;

    interval_set_insert_merge #(
        .MAX_RANGES (MAX_RANGES)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
                     expected_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic note_fail(input string msg);
        n_err++;
        if (n_err <= 10) begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    function automatic isim_pkg::t_out_item predict_insert(input isim_pkg::t_in_item it);
        isim_pkg::t_out_item res;
        logic [32:0] lo, hi, new_lo, new_hi;
        logic [31:0] next_lo [MAX_RANGES];
        logic [31:0] next_hi [MAX_RANGES];
        int          first_idx, stop_idx, fused, w;
        bit          covered;
        res.changed = 1'b0;
        res.status  = isim_pkg::ST_OK;
        lo = {1'b0, it.range_first};
        hi = {1'b0, it.range_last};
        if (lo > hi) begin
            res.status = isim_pkg::ST_BAD;
        end else begin
            first_idx = 0;
            while (first_idx < span_n && {1'b0, span_hi[first_idx]} + 33'd1 < lo)
                first_idx++;
            stop_idx = first_idx;
            while (stop_idx < span_n && {1'b0, span_lo[stop_idx]} <= hi + 33'd1)
                stop_idx++;
            fused = stop_idx - first_idx;
            covered = (fused == 1) && (span_lo[first_idx] <= it.range_first)
                      && (span_hi[first_idx] >= it.range_last);
            if (!covered) begin
                if (fused == 0 && span_n >= MAX_RANGES) begin
                    res.status = isim_pkg::ST_FULL;
                end else begin
                    res.changed = 1'b1;
                    new_lo = lo;
                    new_hi = hi;
                    if (fused > 0) begin
                        if ({1'b0, span_lo[first_idx]} < new_lo)
                            new_lo = {1'b0, span_lo[first_idx]};
                        if ({1'b0, span_hi[stop_idx-1]} > new_hi)
                            new_hi = {1'b0, span_hi[stop_idx-1]};
                    end
                    if (!it.dry_run) begin
                        w = 0;
                        for (int k = 0; k < first_idx; k++) begin
                            next_lo[w] = span_lo[k];
                            next_hi[w] = span_hi[k];
                            w++;
                        end
                        next_lo[w] = new_lo[31:0];
                        next_hi[w] = new_hi[31:0];
                        w++;
                        for (int k = stop_idx; k < span_n; k++) begin
                            next_lo[w] = span_lo[k];
                            next_hi[w] = span_hi[k];
                            w++;
                        end
                        span_lo = next_lo;
                        span_hi = next_hi;
                        span_n  = w;
                    end
                end
            end
        end
        res.entry_count = 5'(span_n);
        return res;
    endfunction

    task automatic check_result(input isim_pkg::t_out_item got);
        isim_pkg::t_out_item want;
        if (expected_q.size() == 0) begin
            note_fail($sformatf("result with nothing pending: changed=%0b status=%0d count=%0d",
                                got.changed, got.status, got.entry_count));
            return;
        end
        want = expected_q.pop_front();
        n_checked++;
        if (want.status == isim_pkg::ST_FULL)
            n_full++;
        if (got.changed !== want.changed || got.status !== want.status
            || got.entry_count !== want.entry_count) begin
            note_fail($sformatf("result %0d changed/status/count: expected %0b/%0d/%0d, %s",
                                n_checked, want.changed, want.status, want.entry_count,
                                $sformatf("got %0b/%0d/%0d", got.changed, got.status,
                                          got.entry_count)));
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                check_result(out_item);
                ready_hold = quiet ? 0 : $urandom_range(0, 6);
                out_ready <= (ready_hold == 0);
            end else if (ready_hold > 0) begin
                ready_hold--;
                out_ready <= (ready_hold == 0);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_range(input logic [31:0] first, input logic [31:0] last,
                              input logic dry);
        int                 gap;
        isim_pkg::t_in_item it;
        gap = quiet ? 0 : $urandom_range(0, 6);
        it.range_first = first;
        it.range_last  = last;
        it.dry_run     = dry;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        expected_q.push_back(predict_insert(it));
        n_sent++;
    endtask

    task automatic wait_results_done;
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_q.size() != 0);
    endtask

    task automatic test_edges;
        send_range(32'd5, 32'd4, 1'b0);
        send_range(32'd1, 32'd1, 1'b1);
        send_range(32'd1, 32'd1, 1'b0);
        send_range(32'd0, 32'd0, 1'b0);
        send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_range(32'hFFFF_FFF0, 32'hFFFF_FFFE, 1'b0);
        send_range(32'd0, 32'd1, 1'b0);
        send_range(32'hFFFF_FFFF, 32'd0, 1'b0);
        send_range(32'd3, 32'd3, 1'b0);
        send_range(32'd2, 32'd2, 1'b1);
        send_range(32'd2, 32'd2, 1'b0);
    endtask

    task automatic test_full_table;
        for (int k = 0; k < 14; k++)
            send_range(32'd10 + 2 * k, 32'd10 + 2 * k, 1'b0);
        send_range(32'd100, 32'd100, 1'b0);
        send_range(32'd100, 32'd100, 1'b1);
        send_range(32'd37, 32'd37, 1'b0);
        send_range(32'd11, 32'd11, 1'b0);
        send_range(32'd0, (32'd1 << REGION_W) - 1, 1'b0);
    endtask

    task automatic run_region_epoch(input int unsigned region, input bit grow_low);
        logic [31:0] rb, re, a, b, t;
        int unsigned kind;
        int          p, q2, pick, j;
        int          inside_q[$];
        bit          dry;
        rb = region << REGION_W;
        re = rb + ((32'd1 << REGION_W) - 1);
        quiet = ($urandom_range(0, 3) == 0);
        repeat (EPOCH_ITEMS) begin
            inside_q = {};
            for (int k = 0; k < span_n; k++)
                if (span_lo[k] >= rb && span_hi[k] <= re)
                    inside_q.push_back(k);
            kind = $urandom_range(0, 99);
            dry  = ($urandom_range(0, 4) == 0);
            a = rb + $urandom_range(0, (1 << REGION_W) - 1);
            b = a + $urandom_range(0, 1 << $urandom_range(0, 12));
            if (b > re)
                b = re;
            if (inside_q.size() > 0 && kind >= 30 && kind < 72) begin
                p    = $urandom_range(0, inside_q.size() - 1);
                pick = inside_q[p];
                if (kind < 40) begin
                    a = span_hi[pick] + 32'd1;
                    b = a + $urandom_range(0, 1 << $urandom_range(0, 10));
                end else if (kind < 50) begin
                    b = span_lo[pick] - 32'd1;
                    a = b - $urandom_range(0, 1 << $urandom_range(0, 10));
                end else if (kind < 62) begin
                    q2 = p + $urandom_range(1, 3);
                    if (q2 >= inside_q.size())
                        q2 = inside_q.size() - 1;
                    j = inside_q[q2];
                    a = span_lo[pick] + $urandom_range(0, span_hi[pick] - span_lo[pick]);
                    if (j != pick && $urandom_range(0, 1))
                        b = span_lo[j] - 32'd1 + $urandom_range(0, 2);
                    else
                        b = span_hi[j] + $urandom_range(0, 1);
                end else begin
                    a = span_lo[pick] + $urandom_range(0, span_hi[pick] - span_lo[pick]);
                    b = a + $urandom_range(0, span_hi[pick] - a);
                end
            end else if (kind >= 72 && kind < 77) begin
                a = $urandom() | 32'd1;
                b = $urandom_range(0, a - 1);
            end else if (kind >= 77 && kind < 85) begin
                a = $urandom();
                b = $urandom();
                if (a > b) begin
                    t = a;
                    a = b;
                    b = t;
                end
                dry = 1'b1;
            end
            send_range(a, b, dry);
        end
        if (grow_low)
            send_range(32'd0, re, 1'b0);
        else
            send_range(rb, 32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_random_regions;
        for (int e = 0; e < EPOCHS; e++) begin
            if (e % 2 == 0)
                run_region_epoch(1 + e / 2, 1'b1);
            else
                run_region_epoch(62 - e / 2, 1'b0);
            if (e % 4 == 3)
                wait_results_done();
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_edges();
        wait_results_done();
        test_full_table();
        wait_results_done();
        test_random_regions();
        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_q.size() != 0)
            note_fail($sformatf("%0d results never arrived", expected_q.size()));
        $display("Sent %0d ranges and checked %0d results (%0d table-full rejects).",
                 n_sent, n_checked, n_full);
        $display("Covered value-space edges, bad ranges, dry runs and %0d random regions.",
                 EPOCHS);
        $display("%0d mismatches.", n_err);
        if (n_err == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== interval_set_insert_merge.f =====
rtl/core/isim_pkg.sv
rtl/core/isim_dp.sv
rtl/core/isim_ctrl.sv
rtl/core/interval_set_insert_merge.sv
tb/tb_top.sv
